// ===== sv/iexu_pkg.sv =====
// Shared types, operation codes and helpers for the integer execute unit.
// Used by iexu_mdu and mips64_integer_execute_unit_top; no dependencies.
package iexu_pkg;

	localparam int unsigned XLEN = 64;
	localparam int unsigned HLEN = 32;
	localparam int unsigned CNT_W = $clog2(XLEN);

	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_ADDI = 6'd2, OP_ADDIU = 6'd3,
		OP_SUB = 6'd4, OP_SUBU = 6'd5, OP_DADD = 6'd6, OP_DADDU = 6'd7,
		OP_DADDI = 6'd8, OP_DADDIU = 6'd9, OP_DSUB = 6'd10, OP_DSUBU = 6'd11,
		OP_AND = 6'd12, OP_OR = 6'd13, OP_XOR = 6'd14, OP_NOR = 6'd15,
		OP_ANDI = 6'd16, OP_ORI = 6'd17, OP_XORI = 6'd18, OP_LUI = 6'd19,
		OP_SLT = 6'd20, OP_SLTU = 6'd21, OP_SLTI = 6'd22, OP_SLTIU = 6'd23,
		OP_SLL = 6'd24, OP_SRL = 6'd25, OP_SRA = 6'd26, OP_SLLV = 6'd27,
		OP_SRLV = 6'd28, OP_SRAV = 6'd29, OP_DSLL = 6'd30, OP_DSRL = 6'd31,
		OP_DSRA = 6'd32, OP_DSLL32 = 6'd33, OP_DSRL32 = 6'd34, OP_DSRA32 = 6'd35,
		OP_DSLLV = 6'd36, OP_DSRLV = 6'd37, OP_DSRAV = 6'd38, OP_MULT = 6'd39,
		OP_MULTU = 6'd40, OP_DIV = 6'd41, OP_DIVU = 6'd42, OP_DMULT = 6'd43,
		OP_DMULTU = 6'd44, OP_DDIV = 6'd45, OP_DDIVU = 6'd46, OP_MFHI = 6'd47,
		OP_MFLO = 6'd48, OP_MTHI = 6'd49, OP_MTLO = 6'd50, OP_TEQ = 6'd51,
		OP_TNE = 6'd52, OP_TGE = 6'd53, OP_TGEU = 6'd54, OP_TLT = 6'd55,
		OP_TLTU = 6'd56, OP_TEQI = 6'd57, OP_TNEI = 6'd58, OP_TGEI = 6'd59,
		OP_TGEIU = 6'd60, OP_TLTI = 6'd61, OP_TLTIU = 6'd62, OP_NOP = 6'd63
	} op_t;

	typedef struct packed {
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic            is_signed;
		logic            is_div;
		logic            is_narrow;
	} mdu_req_t;

	function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] x);
		return {{(XLEN-HLEN){x[HLEN-1]}}, x[HLEN-1:0]};
	endfunction

endpackage

// ===== sv/iexu_mdu.sv =====
// Iterative multiply/divide unit: one shift-add or shift-subtract step per cycle.
// Depends on iexu_pkg.
module iexu_mdu (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  iexu_pkg::mdu_req_t      req,
	output logic                    done,
	output logic [iexu_pkg::XLEN-1:0] hi,
	output logic [iexu_pkg::XLEN-1:0] lo
);

	localparam int unsigned XL = iexu_pkg::XLEN;
	localparam int unsigned CW = iexu_pkg::CNT_W;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic [XL-1:0]  acc_q, lo_q, b_q, a_orig_q;
	logic           div_q, narrow_q, signed_q, sa_q, sb_q, zero_q;

	logic [XL:0]    sum, rem_sh, diff;
	logic [XL-1:0]  abs_a, abs_b, hi_fix, lo_fix, hi_out, lo_out;
	logic           qneg;

	assign abs_a = (req.is_signed && req.a[XL-1]) ? (~req.a + 1'b1) : req.a;
	assign abs_b = (req.is_signed && req.b[XL-1]) ? (~req.b + 1'b1) : req.b;

	assign sum    = {1'b0, acc_q} + (lo_q[0] ? {1'b0, b_q} : {(XL+1){1'b0}});
	assign rem_sh = {acc_q, lo_q[XL-1]};
	assign diff   = rem_sh - {1'b0, b_q};

	assign qneg = sa_q ^ sb_q;

	always_comb begin
		if (!div_q) begin
			hi_fix = qneg ? (~acc_q + {{(XL-1){1'b0}}, (lo_q == '0)}) : acc_q;
			lo_fix = qneg ? (~lo_q + 1'b1) : lo_q;
		end else begin
			hi_fix = sa_q ? (~acc_q + 1'b1) : acc_q;
			lo_fix = qneg ? (~lo_q + 1'b1) : lo_q;
		end
		if (div_q && zero_q) begin
			hi_out = narrow_q ? iexu_pkg::sx32(a_orig_q) : a_orig_q;
			lo_out = (signed_q && a_orig_q[XL-1]) ? {{(XL-1){1'b0}}, 1'b1} : '1;
		end else if (narrow_q && !div_q) begin
			hi_out = iexu_pkg::sx32({{(XL-iexu_pkg::HLEN){1'b0}}, lo_fix[XL-1:iexu_pkg::HLEN]});
			lo_out = iexu_pkg::sx32(lo_fix);
		end else if (narrow_q) begin
			hi_out = iexu_pkg::sx32(hi_fix);
			lo_out = iexu_pkg::sx32(lo_fix);
		end else begin
			hi_out = hi_fix;
			lo_out = lo_fix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= (state_q == S_FIX);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						acc_q    <= '0;
						lo_q     <= abs_a;
						b_q      <= abs_b;
						a_orig_q <= req.a;
						div_q    <= req.is_div;
						narrow_q <= req.is_narrow;
						signed_q <= req.is_signed;
						sa_q     <= req.is_signed && req.a[XL-1];
						sb_q     <= req.is_signed && req.b[XL-1];
						zero_q   <= (req.b == '0);
						cnt_q    <= '1;
						state_q  <= (req.is_div && req.b == '0) ? S_FIX : S_RUN;
					end
				end
				S_RUN: begin
					if (!div_q) begin
						acc_q <= sum[XL:1];
						lo_q  <= {sum[0], lo_q[XL-1:1]};
					end else if (!diff[XL]) begin
						acc_q <= diff[XL-1:0];
						lo_q  <= {lo_q[XL-2:0], 1'b1};
					end else begin
						acc_q <= rem_sh[XL-1:0];
						lo_q  <= {lo_q[XL-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_FIX;
				end
				S_FIX: begin
					hi      <= hi_out;
					lo      <= lo_out;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_from_fix: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_FIX)
		else $error("done without finishing step");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |=> (state_q == S_RUN || state_q == S_FIX))
		else $error("iteration left early");
	a_div0_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && req.is_div && req.b == '0) |=> state_q == S_FIX)
		else $error("divide by zero did not skip iteration");

endmodule

// ===== sv/mips64_integer_execute_unit_top.sv =====
// MIPS64 integer execute unit top level: ALU, shifts, compares, traps, HI/LO.
// Depends on iexu_pkg and iexu_mdu.
//
// ALU, shift, compare, trap and HI/LO move operations are computed combinationally: the
// result is registered and offered the cycle after the input transfer.
// Multiply and divide operations (MULT..DDIVU) are handed to the
// shared shift-add/shift-subtract unit that retires one bit per cycle over
// 64 iterations plus a load and a sign-fixup step; divide by zero skips the
// iterations. A new item is taken once the unit is idle and the output
// register is empty or being drained. Multiply/divide items return a result
// with writes_result low once HI and LO are updated.
module mips64_integer_execute_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  req_type,
	input  logic [63:0] rs_value,
	input  logic [63:0] rt_value,
	input  logic [15:0] immediate,
	input  logic [4:0]  shift_amount,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result,
	output logic        writes_result,
	output logic        trap_taken
);

	localparam int unsigned XL = iexu_pkg::XLEN;

	typedef enum logic [0:0] {S_IDLE, S_BUSY} state_t;

	state_t         state_q;
	logic [XL-1:0]  hi_q, lo_q;
	logic           out_valid_q;
	logic [XL-1:0]  result_q;
	logic           wr_q, trap_q;

	iexu_pkg::op_t      op;
	iexu_pkg::mdu_req_t mreq;
	logic               mstart, mdone;
	logic [XL-1:0]      mhi, mlo;

	logic [XL-1:0] simm, zimm, res, rt32;
	logic          wr, trap, is_md, lt_s, lt_u, eq, lti_s, lti_u, eqi;
	logic [5:0]    sh;
	logic          accept;

	assign op     = iexu_pkg::op_t'(req_type);
	assign simm   = {{(XL-16){immediate[15]}}, immediate};
	assign zimm   = {{(XL-16){1'b0}}, immediate};
	assign rt32   = {{(XL-iexu_pkg::HLEN){1'b0}}, rt_value[iexu_pkg::HLEN-1:0]};
	assign lt_s   = $signed(rs_value) < $signed(rt_value);
	assign lt_u   = rs_value < rt_value;
	assign eq     = rs_value == rt_value;
	assign lti_s  = $signed(rs_value) < $signed(simm);
	assign lti_u  = rs_value < simm;
	assign eqi    = rs_value == simm;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_md    = (op inside {[iexu_pkg::OP_MULT:iexu_pkg::OP_DDIVU]});
	assign mstart   = accept && is_md;

	always_comb begin
		mreq.is_signed = (op inside {iexu_pkg::OP_MULT, iexu_pkg::OP_DIV,
			iexu_pkg::OP_DMULT, iexu_pkg::OP_DDIV});
		mreq.is_div = (op inside {iexu_pkg::OP_DIV, iexu_pkg::OP_DIVU,
			iexu_pkg::OP_DDIV, iexu_pkg::OP_DDIVU});
		mreq.is_narrow = (op inside {[iexu_pkg::OP_MULT:iexu_pkg::OP_DIVU]});
		if (op inside {iexu_pkg::OP_MULT, iexu_pkg::OP_DIV}) begin
			mreq.a = iexu_pkg::sx32(rs_value);
			mreq.b = iexu_pkg::sx32(rt_value);
		end else if (op inside {iexu_pkg::OP_MULTU, iexu_pkg::OP_DIVU}) begin
			mreq.a = {{(XL-iexu_pkg::HLEN){1'b0}}, rs_value[iexu_pkg::HLEN-1:0]};
			mreq.b = rt32;
		end else begin
			mreq.a = rs_value;
			mreq.b = rt_value;
		end
	end

	always_comb begin
		res  = '0;
		wr   = 1'b1;
		trap = 1'b0;
		sh   = '0;
		case (op)
			iexu_pkg::OP_ADD, iexu_pkg::OP_ADDU: res = iexu_pkg::sx32(rs_value + rt_value);
			iexu_pkg::OP_ADDI, iexu_pkg::OP_ADDIU: res = iexu_pkg::sx32(rs_value + simm);
			iexu_pkg::OP_SUB, iexu_pkg::OP_SUBU: res = iexu_pkg::sx32(rs_value - rt_value);
			iexu_pkg::OP_DADD, iexu_pkg::OP_DADDU: res = rs_value + rt_value;
			iexu_pkg::OP_DADDI, iexu_pkg::OP_DADDIU: res = rs_value + simm;
			iexu_pkg::OP_DSUB, iexu_pkg::OP_DSUBU: res = rs_value - rt_value;
			iexu_pkg::OP_AND:  res = rs_value & rt_value;
			iexu_pkg::OP_OR:   res = rs_value | rt_value;
			iexu_pkg::OP_XOR:  res = rs_value ^ rt_value;
			iexu_pkg::OP_NOR:  res = ~(rs_value | rt_value);
			iexu_pkg::OP_ANDI: res = rs_value & zimm;
			iexu_pkg::OP_ORI:  res = rs_value | zimm;
			iexu_pkg::OP_XORI: res = rs_value ^ zimm;
			iexu_pkg::OP_LUI:  res = iexu_pkg::sx32({{(XL-32){1'b0}}, immediate, 16'h0000});
			iexu_pkg::OP_SLT:  res = {{(XL-1){1'b0}}, lt_s};
			iexu_pkg::OP_SLTU: res = {{(XL-1){1'b0}}, lt_u};
			iexu_pkg::OP_SLTI: res = {{(XL-1){1'b0}}, lti_s};
			iexu_pkg::OP_SLTIU: res = {{(XL-1){1'b0}}, lti_u};
			iexu_pkg::OP_SLL: res = iexu_pkg::sx32(rt32 << shift_amount);
			iexu_pkg::OP_SRL: res = iexu_pkg::sx32(rt32 >> shift_amount);
			iexu_pkg::OP_SRA: res = $signed(iexu_pkg::sx32(rt_value)) >>> shift_amount;
			iexu_pkg::OP_SLLV: res = iexu_pkg::sx32(rt32 << rs_value[4:0]);
			iexu_pkg::OP_SRLV: res = iexu_pkg::sx32(rt32 >> rs_value[4:0]);
			iexu_pkg::OP_SRAV: res = $signed(iexu_pkg::sx32(rt_value)) >>> rs_value[4:0];
			iexu_pkg::OP_DSLL: res = rt_value << shift_amount;
			iexu_pkg::OP_DSRL: res = rt_value >> shift_amount;
			iexu_pkg::OP_DSRA: res = $signed(rt_value) >>> shift_amount;
			iexu_pkg::OP_DSLL32: begin
				sh  = {1'b1, shift_amount};
				res = rt_value << sh;
			end
			iexu_pkg::OP_DSRL32: begin
				sh  = {1'b1, shift_amount};
				res = rt_value >> sh;
			end
			iexu_pkg::OP_DSRA32: begin
				sh  = {1'b1, shift_amount};
				res = $signed(rt_value) >>> sh;
			end
			iexu_pkg::OP_DSLLV: res = rt_value << rs_value[5:0];
			iexu_pkg::OP_DSRLV: res = rt_value >> rs_value[5:0];
			iexu_pkg::OP_DSRAV: res = $signed(rt_value) >>> rs_value[5:0];
			iexu_pkg::OP_MFHI: res = hi_q;
			iexu_pkg::OP_MFLO: res = lo_q;
			iexu_pkg::OP_TEQ:  begin wr = 1'b0; trap = eq; end
			iexu_pkg::OP_TNE:  begin wr = 1'b0; trap = !eq; end
			iexu_pkg::OP_TGE:  begin wr = 1'b0; trap = !lt_s; end
			iexu_pkg::OP_TGEU: begin wr = 1'b0; trap = !lt_u; end
			iexu_pkg::OP_TLT:  begin wr = 1'b0; trap = lt_s; end
			iexu_pkg::OP_TLTU: begin wr = 1'b0; trap = lt_u; end
			iexu_pkg::OP_TEQI: begin wr = 1'b0; trap = eqi; end
			iexu_pkg::OP_TNEI: begin wr = 1'b0; trap = !eqi; end
			iexu_pkg::OP_TGEI: begin wr = 1'b0; trap = !lti_s; end
			iexu_pkg::OP_TGEIU: begin wr = 1'b0; trap = !lti_u; end
			iexu_pkg::OP_TLTI: begin wr = 1'b0; trap = lti_s; end
			iexu_pkg::OP_TLTIU: begin wr = 1'b0; trap = lti_u; end
			default: wr = 1'b0;
		endcase
	end

	iexu_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.req    (mreq),
		.done   (mdone),
		.hi     (mhi),
		.lo     (mlo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			hi_q        <= '0;
			lo_q        <= '0;
			result_q    <= '0;
			wr_q        <= 1'b0;
			trap_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !(accept && !is_md))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_md) begin
							state_q <= S_BUSY;
						end else begin
							if (op == iexu_pkg::OP_MTHI)
								hi_q <= rs_value;
							if (op == iexu_pkg::OP_MTLO)
								lo_q <= rs_value;
							result_q    <= wr ? res : '0;
							wr_q        <= wr;
							trap_q      <= trap;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_BUSY: begin
					if (mdone) begin
						hi_q        <= mhi;
						lo_q        <= mlo;
						result_q    <= '0;
						wr_q        <= 1'b0;
						trap_q      <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result        = result_q;
	assign writes_result = wr_q;
	assign trap_taken    = trap_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUSY) |-> !in_ready)
		else $error("transfer taken while multiply/divide in progress");
	a_trap_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(trap_taken && writes_result))
		else $error("trap and register write together");
	a_zero_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !writes_result) |-> result == '0)
		else $error("nonzero result without write");
	a_md_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUSY && mdone) |=> (out_valid && state_q == S_IDLE))
		else $error("multiply/divide completion lost");

endmodule
